[hdl/sfe_pkg.sv]
// shared constants, types and register codes for the stereo feedback echo
package sfe_pkg;

	localparam int RING_FRAMES = 65536;
	localparam int SAMPLE_BITS = 16;
	localparam int RING_AW     = (RING_FRAMES > 1) ? $clog2(RING_FRAMES) : 1;
	localparam int DLY_W       = 16;
	localparam int GAIN_W      = 16;
	localparam int CNT_W       = 17;
	localparam int GAIN_FRAC   = 15;
	localparam int FRAME_W     = 2 * SAMPLE_BITS;
	localparam int TDATA_W     = ((FRAME_W + 7) / 8) * 8;
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [GAIN_W-1:0]      gain_t;
	typedef logic [DLY_W-1:0]              delay_t;
	typedef logic [RING_AW-1:0]            slot_t;
	typedef logic [CNT_W-1:0]              count_t;
	typedef logic [FRAME_W-1:0]            frame_t;

	// register indexes, decoded from paddr[2]
	localparam logic REG_DELAY = 1'b0;
	localparam logic REG_GAIN  = 1'b1;

	localparam delay_t DELAY_RESET = 16'd22050;
	localparam gain_t  GAIN_RESET  = 16'sd16384;
	localparam delay_t DELAY_CAP   = (RING_FRAMES > (1 << DLY_W)) ? {DLY_W{1'b1}} :
	                                 DLY_W'(RING_FRAMES - 1);
	localparam count_t CNT_MAX     = {CNT_W{1'b1}};
	localparam slot_t  SLOT_LAST   = RING_AW'(RING_FRAMES - 1);

	typedef struct packed {
		logic   en;
		slot_t  addr;
		frame_t data;
	} ring_wr_t;

	typedef struct packed {
		logic  en;
		slot_t addr;
	} ring_rd_t;

endpackage

[hdl/stereo_feedback_echo.sv]
// top level: stereo feedback echo with frame ring, two channel lanes and output register
//
// One stereo frame is taken per clock and its result passes the s1 and output
// registers; the input side stalls only while the output register holds an untaken
// result and a frame waits behind it. The rate is set by the ring memory, with one
// write and one read port, and by the feedback path of each lane: with a delay of
// one frame the previous result is taken from the output register, so the multiply,
// add and saturate of a lane close the loop combinationally. No clearing pass of the
// ring is needed after reset, as a read only reaches entries written in the region.
module stereo_feedback_echo
	import sfe_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [TDATA_W-1:0]  s_tdata,   // left_in, right_in
	input  logic [0:0]          s_tuser,   // first_frame
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [TDATA_W-1:0]  m_tdata,   // left_out, right_out
	output logic                m_tlast,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready
);

	delay_t   delay_q;
	gain_t    gain_q;
	slot_t    write_slot_q;
	count_t   seen_q;

	logic     s1_valid_q;
	sample_t  left_s1, right_s1;
	logic     last_s1, echo_s1, fwd_s1;
	slot_t    slot_s1;

	logic     m_valid_q;
	sample_t  left_out_q, right_out_q;
	logic     last_out_q;

	logic     in_xfer, adv, cfg_wr;
	delay_t   d_eff;
	slot_t    d_slot, rd_slot, next_slot;
	count_t   cnt_eff, cnt_next;
	logic     echo_en;
	sample_t  left_in, right_in;

	ring_wr_t ring_wr;
	ring_rd_t ring_rd;
	frame_t   ring_data;
	sample_t  past_l, past_r, lane_l, lane_r;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RESET;
			gain_q  <= GAIN_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_DELAY: delay_q <= pwdata[DLY_W-1:0];
				REG_GAIN:  gain_q  <= gain_t'(pwdata[GAIN_W-1:0]);
				default:   delay_q <= delay_q;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_DELAY: prdata = APB_DW'(delay_q);
			REG_GAIN:  prdata = APB_DW'(gain_q);
			default:   prdata = '0;
		endcase
	end

	// input stage
	assign adv      = s1_valid_q && (!m_valid_q || m_tready);
	assign s_tready = !s1_valid_q || !m_valid_q || m_tready;
	assign in_xfer  = s_tvalid && s_tready;
	assign left_in  = sample_t'(s_tdata[SAMPLE_BITS-1:0]);
	assign right_in = sample_t'(s_tdata[FRAME_W-1:SAMPLE_BITS]);

	always_comb begin
		if (delay_q == '0) begin
			d_eff = delay_t'(1);
		end else if (delay_q > DELAY_CAP) begin
			d_eff = DELAY_CAP;
		end else begin
			d_eff = delay_q;
		end
		d_slot    = slot_t'(d_eff);
		rd_slot   = (write_slot_q >= d_slot) ? slot_t'(write_slot_q - d_slot) :
		            slot_t'(write_slot_q + RING_FRAMES - d_slot);
		next_slot = (write_slot_q == SLOT_LAST) ? '0 : slot_t'(write_slot_q + 1'b1);
		cnt_eff   = s_tuser[0] ? '0 : seen_q;
		echo_en   = cnt_eff >= CNT_W'(d_eff);
		cnt_next  = (cnt_eff == CNT_MAX) ? cnt_eff : count_t'(cnt_eff + 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q <= '0;
			seen_q       <= '0;
			s1_valid_q   <= 1'b0;
		end else begin
			if (in_xfer) begin
				write_slot_q <= next_slot;
				seen_q       <= cnt_next;
			end
			if (in_xfer) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			left_s1  <= left_in;
			right_s1 <= right_in;
			last_s1  <= s_tlast;
			echo_s1  <= echo_en;
			slot_s1  <= write_slot_q;
			// frame ahead is written at this edge, so its result comes from the output register
			fwd_s1   <= s1_valid_q && (rd_slot == slot_s1);
		end
	end

	// ring memory
	assign ring_rd.en   = in_xfer;
	assign ring_rd.addr = rd_slot;
	assign ring_wr.en   = adv;
	assign ring_wr.addr = slot_s1;
	assign ring_wr.data = {lane_r, lane_l};

	sfe_ring u_ring (
		.clk     (clk),
		.wr      (ring_wr),
		.rd      (ring_rd),
		.rd_data (ring_data)
	);

	// channel lanes
	assign past_l = fwd_s1 ? left_out_q  : sample_t'(ring_data[SAMPLE_BITS-1:0]);
	assign past_r = fwd_s1 ? right_out_q : sample_t'(ring_data[FRAME_W-1:SAMPLE_BITS]);

	sfe_lane u_lane_l (
		.echo_en    (echo_s1),
		.sample_in  (left_s1),
		.past       (past_l),
		.gain       (gain_q),
		.sample_out (lane_l)
	);

	sfe_lane u_lane_r (
		.echo_en    (echo_s1),
		.sample_in  (right_s1),
		.past       (past_r),
		.gain       (gain_q),
		.sample_out (lane_r)
	);

	// merge into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			left_out_q  <= lane_l;
			right_out_q <= lane_r;
			last_out_q  <= last_s1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = TDATA_W'({right_out_q, left_out_q});
	assign m_tlast  = last_out_q;

endmodule

[hdl/sfe_ring.sv]
// ring of past result frames, one write and one registered read per cycle
module sfe_ring
	import sfe_pkg::*;
(
	input  logic     clk,
	input  ring_wr_t wr,
	input  ring_rd_t rd,
	output frame_t   rd_data
);

	frame_t mem [RING_FRAMES];
	frame_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/sfe_lane.sv]
// channel lane: echo_en ? saturated input plus rounded gain product : input
module sfe_lane
	import sfe_pkg::*;
(
	input  logic    echo_en,
	input  sample_t sample_in,
	input  sample_t past,
	input  gain_t   gain,
	output sample_t sample_out
);

	localparam int ACC_W = SAMPLE_BITS + GAIN_W + 2;
	localparam logic signed [ACC_W-1:0] S_HI =
		ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [ACC_W-1:0] S_LO = -S_HI - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] ROUND = ACC_W'(64'sd1 <<< (GAIN_FRAC - 1));

	logic signed [SAMPLE_BITS+GAIN_W-1:0] prod;
	logic signed [ACC_W-1:0]              acc;
	logic signed [ACC_W-1:0]              quo;
	sample_t                              sat;

	always_comb begin
		prod = past * gain;
		acc  = (ACC_W'(sample_in) <<< GAIN_FRAC) + ACC_W'(prod) + ROUND;
		quo  = acc >>> GAIN_FRAC;
		priority if (quo > S_HI) begin
			sat = SAMPLE_BITS'(S_HI);
		end else if (quo < S_LO) begin
			sat = SAMPLE_BITS'(S_LO);
		end else begin
			sat = SAMPLE_BITS'(quo);
		end
	end

	assign sample_out = echo_en ? sat : sample_in;

endmodule

[hdl/sfe_checker.sv]
// port-level checks for the stereo feedback echo, bound to the top level
module sfe_checker
	import sfe_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [TDATA_W-1:0]  m_tdata,
	input logic                m_tlast,
	input logic                psel,
	input logic                penable,
	input logic                pwrite,
	input logic [APB_AW-1:0]   paddr,
	input logic [APB_DW-1:0]   pwdata,
	input logic [APB_DW-1:0]   prdata,
	input logic                pready
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// input only backs up behind a waiting result
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output back-pressure");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

	// delay register reads back what was written
	a_delay_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && !paddr[2]) ##1 !paddr[2]
		|-> prdata[DLY_W-1:0] == $past(pwdata[DLY_W-1:0]))
		else $error("delay readback mismatch");

endmodule

bind stereo_feedback_echo sfe_checker u_sfe_checker (.*);

[bench/tb_stereo_feedback_echo.sv]
// testbench for the stereo feedback echo: streamed frames checked against a predicted echo
`timescale 1ns / 1ps
module tb_stereo_feedback_echo;
	import sfe_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_SHOWN    = 40;
	localparam int LONG_FRAMES  = 64;
	localparam logic [APB_AW-1:0] ADDR_DELAY = {REG_DELAY, 2'b00};
	localparam logic [APB_AW-1:0] ADDR_GAIN  = {REG_GAIN, 2'b00};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam gain_t   GAIN_MIN   = {1'b1, {(GAIN_W-1){1'b0}}};
	localparam gain_t   GAIN_MAX   = {1'b0, {(GAIN_W-1){1'b1}}};

	logic               clk;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata  = '0;   // left_in, right_in
	logic [0:0]         s_tuser  = '0;   // first_frame
	logic               s_tlast  = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;         // left_out, right_out
	logic               m_tlast;
	logic               psel     = 1'b0;
	logic               penable  = 1'b0;
	logic               pwrite   = 1'b0;
	logic [APB_AW-1:0]  paddr    = '0;
	logic [APB_DW-1:0]  pwdata   = '0;
	logic [APB_DW-1:0]  prdata;
	logic               pready;

	typedef struct {
		sample_t left;
		sample_t right;
		logic    eor;
	} echo_frame_t;

	echo_frame_t echo_due[$];
	frame_t      out_hist [RING_FRAMES];
	slot_t       hist_slot;
	count_t      region_len;
	delay_t      cur_delay;
	gain_t       cur_gain;

	int src_idle_pct    = 0;
	int snk_idle_pct    = 0;
	int rx_hold         = 0;
	int err_count       = 0;
	int frames_sent     = 0;
	int results_checked = 0;
	int reg_writes      = 0;
	int cycle_count     = 0;

	stereo_feedback_echo u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void report_mismatch(string what, int want, int got);
		err_count++;
		if (err_count <= MAX_SHOWN)
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
	endfunction

	// rounded gain product added to the input, clamped to the sample range
	function automatic sample_t mix_sample(sample_t x, sample_t past);
		longint acc;
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
		lo = -hi - 1;
		acc = longint'(x) * (longint'(1) <<< GAIN_FRAC) + longint'(cur_gain) * longint'(past)
		      + (longint'(1) <<< (GAIN_FRAC - 1));
		acc = acc >>> GAIN_FRAC;
		if (acc > hi)
			acc = hi;
		if (acc < lo)
			acc = lo;
		return sample_t'(acc);
	endfunction

	function automatic void predict_echo(sample_t l, sample_t r, logic first, logic last);
		int unsigned d;
		slot_t       rd;
		echo_frame_t res;
		d = cur_delay;
		if (d == 0)
			d = 1;
		if (d >= RING_FRAMES)
			d = RING_FRAMES - 1;
		if (first)
			region_len = '0;
		res.left  = l;
		res.right = r;
		res.eor   = last;
		if (region_len >= d) begin
			rd = hist_slot - slot_t'(d);
			res.left  = mix_sample(l, sample_t'(out_hist[rd][SAMPLE_BITS-1:0]));
			res.right = mix_sample(r, sample_t'(out_hist[rd][FRAME_W-1:SAMPLE_BITS]));
		end
		out_hist[hist_slot] = {res.right, res.left};
		hist_slot = hist_slot + 1'b1;
		if (region_len != CNT_MAX)
			region_len = region_len + 1'b1;
		echo_due.push_back(res);
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MIN;
			1: return SAMPLE_MAX;
			2: return sample_t'($urandom_range(0, 600)) - sample_t'(300);
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic send_frame(sample_t l, sample_t r, logic first, logic last);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {r, l};
		s_tuser  <= first;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		predict_echo(l, r, first, last);
		frames_sent++;
	endtask

	task automatic end_burst();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		while (echo_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(logic wr, logic [APB_AW-1:0] addr, logic [APB_DW-1:0] wdata,
	                          output logic [APB_DW-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		logic [APB_AW-1:0] addr;
		logic [APB_DW-1:0] rd;
		wait_idle();
		addr = {idx, 2'b00};
		apb_access(1'b1, addr, {16'($urandom), val}, rd);
		if (idx == REG_DELAY)
			cur_delay = val;
		else
			cur_gain = val;
		reg_writes++;
		apb_access(1'b0, addr, '0, rd);
		if (rd[15:0] !== val)
			report_mismatch(idx == REG_DELAY ? "delay_frames readback" : "echo_gain readback",
			                int'(val), int'(rd[15:0]));
	endtask

	task automatic check_result();
		echo_frame_t want;
		if (echo_due.size() == 0) begin
			err_count++;
			if (err_count <= MAX_SHOWN)
				$display("%0t: result with no frame pending, tdata %h", $time, m_tdata);
		end else begin
			want = echo_due.pop_front();
			results_checked++;
			if (sample_t'(m_tdata[SAMPLE_BITS-1:0]) !== want.left)
				report_mismatch("left_out", want.left, sample_t'(m_tdata[SAMPLE_BITS-1:0]));
			if (sample_t'(m_tdata[FRAME_W-1:SAMPLE_BITS]) !== want.right)
				report_mismatch("right_out", want.right, sample_t'(m_tdata[FRAME_W-1:SAMPLE_BITS]));
			if (m_tlast !== want.eor)
				report_mismatch("end_of_region", int'(want.eor), int'(m_tlast));
		end
	endtask

	// receiver side: checks each transfer and paces m_tready
	initial begin
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				check_result();
			if (rx_hold > 0) begin
				rx_hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
			end
		end
	end

	task automatic pick_config();
		delay_t d;
		gain_t  g;
		case ($urandom_range(0, 9))
			0: d = '0;
			1: d = delay_t'(1);
			2: d = delay_t'($urandom_range(100, 300));
			default: d = delay_t'($urandom_range(2, 24));
		endcase
		case ($urandom_range(0, 7))
			0: g = GAIN_MIN;
			1: g = GAIN_MAX;
			2: g = '0;
			default: g = gain_t'($urandom);
		endcase
		write_reg(REG_DELAY, d);
		write_reg(REG_GAIN, g);
	endtask

	task automatic run_traffic(int src_pct, int snk_pct, int n_frames);
		int          sent;
		int          len;
		int unsigned deff;
		bit          tidy;
		logic        first;
		logic        last;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		sent = 0;
		while (sent < n_frames) begin
			if (sent == 0 || $urandom_range(0, 99) < 30) begin
				end_burst();
				pick_config();
			end
			deff = (cur_delay == 0) ? 1 : cur_delay;
			len = (deff > 64) ? deff + $urandom_range(1, 40) : $urandom_range(1, 3 * deff + 8);
			tidy = ($urandom_range(0, 99) < 85);
			for (int i = 0; i < len; i++) begin
				if (tidy) begin
					first = (i == 0);
					last  = (i == len - 1);
				end else begin
					first = ($urandom_range(0, 9) == 0);
					last  = ($urandom_range(0, 9) == 0);
				end
				send_frame(pick_sample(), pick_sample(), first, last);
			end
			sent += len;
		end
		end_burst();
	endtask

	task automatic test_register_access();
		logic [APB_DW-1:0] rd;
		apb_access(1'b0, ADDR_DELAY, '0, rd);
		if (rd[15:0] !== DELAY_RESET)
			report_mismatch("delay_frames after reset", int'(DELAY_RESET), int'(rd[15:0]));
		apb_access(1'b0, ADDR_GAIN, '0, rd);
		if (rd[15:0] !== GAIN_RESET)
			report_mismatch("echo_gain after reset", int'(GAIN_RESET), int'(rd[15:0]));
		write_reg(REG_DELAY, DELAY_CAP);
		write_reg(REG_DELAY, '0);
		write_reg(REG_DELAY, 16'h5aa5);
		write_reg(REG_GAIN, GAIN_MAX);
		write_reg(REG_GAIN, GAIN_MIN);
		write_reg(REG_GAIN, '0);
		write_reg(REG_DELAY, DELAY_RESET);
		write_reg(REG_GAIN, GAIN_RESET);
	endtask

	task automatic test_directed_frames();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		// no first mark yet: region counted from reset, long delay passes through
		send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0, 1'b0);
		send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0, 1'b0);
		send_frame(16'sd0, -16'sd1, 1'b0, 1'b1);
		end_burst();
		// zero delay acts as one frame, full gain saturates both ways
		write_reg(REG_DELAY, '0);
		write_reg(REG_GAIN, GAIN_MAX);
		send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b1, 1'b0);
		send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0, 1'b0);
		send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0, 1'b1);
		// frame after the last mark carries on the region
		send_frame(16'sd0, 16'sd0, 1'b0, 1'b0);
		end_burst();
		write_reg(REG_GAIN, GAIN_MIN);
		write_reg(REG_DELAY, delay_t'(1));
		send_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b1, 1'b0);
		send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0, 1'b0);
		send_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b0, 1'b1);
		end_burst();
		// half-way rounding of the gain product
		write_reg(REG_GAIN, gain_t'(1));
		send_frame(16'sd16384, -16'sd16384, 1'b1, 1'b0);
		send_frame(16'sd0, 16'sd0, 1'b0, 1'b0);
		send_frame(16'sd0, 16'sd0, 1'b0, 1'b0);
		send_frame(-16'sd1, 16'sd1, 1'b0, 1'b1);
		end_burst();
		// first mark in mid region restarts the count
		write_reg(REG_DELAY, delay_t'(2));
		write_reg(REG_GAIN, GAIN_RESET);
		send_frame(16'sd1000, -16'sd1000, 1'b1, 1'b0);
		send_frame(16'sd2000, -16'sd2000, 1'b0, 1'b0);
		send_frame(16'sd0, 16'sd0, 1'b0, 1'b0);
		send_frame(16'sd0, 16'sd0, 1'b1, 1'b0);
		send_frame(16'sd5, 16'sd5, 1'b0, 1'b0);
		send_frame(16'sd7, -16'sd7, 1'b0, 1'b1);
		end_burst();
	endtask

	task automatic test_random_traffic();
		run_traffic(6, 68, 360);
		run_traffic(68, 6, 360);
		run_traffic(0, 0, 360);
	endtask

	task automatic test_output_backpressure();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_reg(REG_DELAY, delay_t'(3));
		write_reg(REG_GAIN, gain_t'($urandom));
		rx_hold = 400;
		for (int i = 0; i < 80; i++)
			send_frame(pick_sample(), pick_sample(), i == 0, i == 79);
		end_burst();
	endtask

	// longest delay: a short region passes straight through
	task automatic test_long_region();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		write_reg(REG_DELAY, DELAY_CAP);
		write_reg(REG_GAIN, gain_t'($urandom_range(8000, 30000)) * gain_t'(-1));
		for (int i = 0; i < LONG_FRAMES; i++)
			send_frame(pick_sample(), pick_sample(), i == 0, $urandom_range(0, 999) == 0);
		end_burst();
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run stopped at the cycle limit of %0d", CYCLE_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin
		hist_slot  = '0;
		region_len = '0;
		cur_delay  = DELAY_RESET;
		cur_gain   = GAIN_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_access();
		test_directed_frames();
		test_random_traffic();
		test_output_backpressure();
		test_long_region();
		wait_idle();
		if (echo_due.size() != 0) begin
			err_count++;
			$display("%0t: %0d frames still awaiting a result", $time, echo_due.size());
		end
		$display("%0d frames sent, %0d results checked, %0d register writes, %0d errors",
		         frames_sent, results_checked, reg_writes, err_count);
		$display("covered extremes, rounding, saturation, region restarts, stalls, longest delay");
		if (err_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
